/* src/nsm_pkg.sv */
// Shared types, constants and helper functions for the negation scope marker.
// Used by every module of the block; depends on nothing else.

package nsm_pkg;

    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned MAX_RESULTS  = 6;
    localparam int unsigned CNT_W        = 3;
    localparam int unsigned KW_COUNT     = 11;
    localparam int unsigned KW_MAXLEN    = 7;
    localparam int unsigned TOK_POS_W    = 4;
    localparam int unsigned KEYWORD_LENGTH_LIMIT = 8;

    localparam logic [BYTE_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [KW_COUNT-1:0] ALL_CANDIDATES = '1;

    typedef logic [BYTE_W-1:0] byte_t;

    typedef struct packed {
        logic                    inside_token;
        logic                    negating;
        logic                    holding_punct;
        byte_t                   held_byte;
        byte_t                   previous_byte;
        logic [TOK_POS_W-1:0]    token_position;
        logic [KW_COUNT-1:0]     keyword_candidates;
    } scan_state_t;

    // Bytes caused by one input byte, in output order, and how many there are.
    typedef struct packed {
        logic [MAX_RESULTS-1:0][BYTE_W-1:0] data;
        logic [CNT_W-1:0]                   count;
    } result_t;

    function automatic logic is_punct(input byte_t b);
        return (b == "?") || (b == ",") || (b == ";") ||
               (b == "!") || (b == ".") || (b == ":");
    endfunction

    // Keyword text, left-justified, zero padded.
    function automatic logic [KW_MAXLEN*BYTE_W-1:0] kw_text(input logic [3:0] k);
        logic [KW_MAXLEN*BYTE_W-1:0] w;
        case (k)
            4'd0:    w = {"nunca", 16'h0};
            4'd1:    w = {"no", 40'h0};
            4'd2:    w = {"nada", 24'h0};
            4'd3:    w = {"ningun", 8'h0};
            4'd4:    w = {"ni", 40'h0};
            4'd5:    w = "ninguno";
            4'd6:    w = "ninguna";
            4'd7:    w = {"jam", 8'hC3, 8'hA1, "s", 8'h00};
            4'd8:    w = {"jamas", 16'h0};
            4'd9:    w = "tampoco";
            4'd10:   w = {"sin", 32'h0};
            default: w = '0;
        endcase
        return w;
    endfunction

    function automatic logic [2:0] kw_len(input logic [3:0] k);
        logic [2:0] l;
        case (k)
            4'd0:    l = 3'd5;
            4'd1:    l = 3'd2;
            4'd2:    l = 3'd4;
            4'd3:    l = 3'd6;
            4'd4:    l = 3'd2;
            4'd5:    l = 3'd7;
            4'd6:    l = 3'd7;
            4'd7:    l = 3'd6;
            4'd8:    l = 3'd5;
            4'd9:    l = 3'd7;
            4'd10:   l = 3'd3;
            default: l = 3'd0;
        endcase
        return l;
    endfunction

    function automatic byte_t kw_char(input logic [3:0] k, input logic [2:0] pos);
        logic [KW_MAXLEN*BYTE_W-1:0] w;
        w = kw_text(k);
        return w[(KW_MAXLEN*BYTE_W-1) - BYTE_W*pos -: BYTE_W];
    endfunction

    function automatic result_t put_byte(input result_t r, input byte_t b);
        result_t o;
        o = r;
        o.data[o.count] = b;
        o.count = o.count + CNT_W'(1);
        return o;
    endfunction

    function automatic result_t put_prefix(input result_t r);
        result_t o;
        o = put_byte(r, "N");
        o = put_byte(o, "E");
        o = put_byte(o, "G");
        o = put_byte(o, "_");
        return o;
    endfunction

endpackage

/* src/nsm_scan.sv */
// Token tracking, keyword matching and negation scope state for one text byte.
// Depends on nsm_pkg for the state and result types and the keyword table.

module nsm_scan #(
    parameter int unsigned KEYWORD_LENGTH_LIMIT = nsm_pkg::KEYWORD_LENGTH_LIMIT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  nsm_pkg::byte_t   cur_byte,
    input  logic             advance,
    output nsm_pkg::result_t result
);

    nsm_pkg::scan_state_t state_reg;
    nsm_pkg::scan_state_t state_next;
    logic                 matched;

    // A finished token is a keyword when a surviving candidate has its length.
    always_comb
    begin
        matched = 1'b0;
        for (int k = 0; k < nsm_pkg::KW_COUNT; k++)
        begin
            if (state_reg.keyword_candidates[k] &&
                ({1'b0, nsm_pkg::kw_len(4'(k))} == state_reg.token_position))
            begin
                matched = 1'b1;
            end
        end
    end

    always_comb
    begin
        nsm_pkg::result_t r;
        logic             lone;
        r          = '0;
        lone       = 1'b0;
        state_next = state_reg;

        if (state_reg.holding_punct)
        begin
            state_next.holding_punct = 1'b0;
            if ((cur_byte == nsm_pkg::CHAR_SPACE) || (cur_byte == nsm_pkg::CHAR_NEWLINE))
            begin
                r = nsm_pkg::put_byte(r, state_reg.held_byte);
                state_next.negating = 1'b0;
            end
            else
            begin
                r = nsm_pkg::put_prefix(r);
                r = nsm_pkg::put_byte(r, state_reg.held_byte);
            end
        end

        if (cur_byte == nsm_pkg::CHAR_NEWLINE)
        begin
            if (state_reg.previous_byte == nsm_pkg::CHAR_SPACE)
            begin
                r = nsm_pkg::put_byte(r, nsm_pkg::CHAR_SPACE);
            end
            r = nsm_pkg::put_byte(r, nsm_pkg::CHAR_NEWLINE);
            state_next.negating           = 1'b0;
            state_next.inside_token       = 1'b0;
            state_next.previous_byte      = nsm_pkg::CHAR_NEWLINE;
            state_next.token_position     = '0;
            state_next.keyword_candidates = nsm_pkg::ALL_CANDIDATES;
        end
        else if (cur_byte == nsm_pkg::CHAR_SPACE)
        begin
            if (state_reg.inside_token)
            begin
                if (state_next.negating)
                begin
                    if (nsm_pkg::is_punct(state_reg.previous_byte))
                    begin
                        state_next.negating = 1'b0;
                    end
                end
                else if (matched)
                begin
                    state_next.negating = 1'b1;
                end
                state_next.inside_token       = 1'b0;
                state_next.previous_byte      = nsm_pkg::CHAR_SPACE;
                state_next.token_position     = '0;
                state_next.keyword_candidates = nsm_pkg::ALL_CANDIDATES;
            end
        end
        else
        begin
            if (!state_reg.inside_token)
            begin
                if (state_reg.previous_byte == nsm_pkg::CHAR_SPACE)
                begin
                    r = nsm_pkg::put_byte(r, nsm_pkg::CHAR_SPACE);
                end
                state_next.inside_token       = 1'b1;
                state_next.token_position     = '0;
                state_next.keyword_candidates = nsm_pkg::ALL_CANDIDATES;
                // Punctuation opening a token in scope waits one byte to see
                // whether it stands alone.
                if (state_next.negating && nsm_pkg::is_punct(cur_byte))
                begin
                    lone                     = 1'b1;
                    state_next.holding_punct = 1'b1;
                    state_next.held_byte     = cur_byte;
                end
                else if (state_next.negating)
                begin
                    r = nsm_pkg::put_prefix(r);
                end
            end
            if (!lone)
            begin
                r = nsm_pkg::put_byte(r, cur_byte);
            end
            for (int k = 0; k < nsm_pkg::KW_COUNT; k++)
            begin
                if ((state_next.token_position >= {1'b0, nsm_pkg::kw_len(4'(k))}) ||
                    (nsm_pkg::kw_char(4'(k), state_next.token_position[2:0]) != cur_byte))
                begin
                    state_next.keyword_candidates[k] = 1'b0;
                end
            end
            if (state_next.token_position <
                nsm_pkg::TOK_POS_W'(KEYWORD_LENGTH_LIMIT))
            begin
                state_next.token_position = state_next.token_position + 4'd1;
            end
            state_next.previous_byte = cur_byte;
        end

        result = r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.inside_token       <= 1'b0;
            state_reg.negating           <= 1'b0;
            state_reg.holding_punct      <= 1'b0;
            state_reg.held_byte          <= '0;
            state_reg.previous_byte      <= '0;
            state_reg.token_position     <= '0;
            state_reg.keyword_candidates <= nsm_pkg::ALL_CANDIDATES;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* src/nsm_emit.sv */
// Result buffer that holds the bytes caused by one input byte and sends them
// out one per cycle while out_ready is high. Depends on nsm_pkg for the result type.

module nsm_emit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  nsm_pkg::result_t result,
    output logic             free,
    output logic             out_valid,
    input  logic             out_ready,
    output nsm_pkg::byte_t   out_byte,
    output logic             last_of_run
);

    logic [nsm_pkg::MAX_RESULTS-1:0][nsm_pkg::BYTE_W-1:0] data_reg;
    logic [nsm_pkg::CNT_W-1:0] cnt_reg;
    logic [nsm_pkg::CNT_W-1:0] idx_reg;
    logic [nsm_pkg::CNT_W-1:0] idx_next;
    logic                      busy_reg;
    logic                      busy_next;
    logic                      is_last;

    assign is_last     = (idx_reg == (cnt_reg - nsm_pkg::CNT_W'(1)));
    assign out_valid   = busy_reg;
    assign out_byte    = data_reg[idx_reg];
    assign last_of_run = is_last;
    // The buffer can take new bytes in the same cycle its final byte leaves.
    assign free        = !busy_reg || (out_ready && is_last);

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (busy_reg && out_ready)
        begin
            if (is_last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + nsm_pkg::CNT_W'(1);
            end
        end
        if (load)
        begin
            busy_next = (result.count != '0);
            idx_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result.data;
            cnt_reg  <= result.count;
        end
    end

endmodule

/* src/negation_scope_marker_core.sv */
// Top level of the negation scope marker: input register, byte scanner and
// result buffer. Depends on nsm_pkg, nsm_scan and nsm_emit.
//
//  Channel | Handshake            | Payload
//  --------+----------------------+--------------------------
//  input   | in_valid / in_ready  | in_byte
//  output  | out_valid / out_ready| out_byte, last_of_run
//
// An input byte goes through the input register, then the result buffer.
// The output port carries one byte per cycle while out_ready is high, so an item
// that causes N result bytes holds the result buffer until all N have left; items
// with at most one result byte flow at one per cycle while the output does not stall.
// Reset clears the scope state, the input register and the result buffer.
// A stall on the output holds the buffer, and the input register fills and
// then holds in_ready low until the buffer drains.

module negation_scope_marker_core #(
    parameter int unsigned KEYWORD_LENGTH_LIMIT = nsm_pkg::KEYWORD_LENGTH_LIMIT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  nsm_pkg::byte_t in_byte,
    output logic           out_valid,
    input  logic           out_ready,
    output nsm_pkg::byte_t out_byte,
    output logic           last_of_run
);

    nsm_pkg::byte_t   in_byte_reg;
    logic             in_vld_reg;
    logic             in_vld_next;
    logic             load;
    logic             free;
    nsm_pkg::result_t result;

    assign load        = in_vld_reg && free;
    assign in_ready    = !in_vld_reg || load;
    assign in_vld_next = (in_valid && in_ready) || (in_vld_reg && !load);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= in_byte;
        end
    end

    nsm_scan #(
        .KEYWORD_LENGTH_LIMIT(KEYWORD_LENGTH_LIMIT)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .cur_byte (in_byte_reg),
        .advance  (load),
        .result   (result)
    );

    nsm_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (load),
        .result      (result),
        .free        (free),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

endmodule

/* src/nsm_checker.sv */
// Port-level checks for the negation scope marker, bound to the top level.
// Depends on nsm_pkg for the byte type and character constants.

module nsm_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_ready,
    input nsm_pkg::byte_t in_byte,
    input logic           out_valid,
    input logic           out_ready,
    input nsm_pkg::byte_t out_byte,
    input logic           last_of_run
);

    // A stalled result byte must not change.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last_of_run))
        else $error("result byte changed while stalled");

    // The bytes of one run leave back to back.
    a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_run |=> out_valid)
        else $error("gap inside a run of result bytes");

    // A newline is always the final byte of its run.
    a_newline_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_byte == nsm_pkg::CHAR_NEWLINE) |-> last_of_run)
        else $error("newline not at end of run");

    // An empty result buffer always lets the input side move.
    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked while no result byte is waiting");

    // A stalled input transfer keeps its byte.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_byte))
        else $error("input byte changed while stalled");

endmodule

bind negation_scope_marker_core nsm_checker u_nsm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
);

/* tb/negation_scope_marker_core_tb.sv */
// Self-checking testbench for negation_scope_marker_core: a directed table is checked against
// its expected bytes and random Spanish-like text against a scope-marking predictor, byte by byte.
// Depends on nsm_pkg and the RTL of the block only.

module negation_scope_marker_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int    HALF_PERIOD  = 5;
    localparam int    RESET_CYCLES = 10;
    localparam int    DIRECTED     = 26;
    localparam int    TOTAL_ITEMS  = 320;
    localparam int    RANDOM_ITEMS = TOTAL_ITEMS - DIRECTED;
    localparam int    TAIL_ITEMS   = 40;
    localparam int    DRAIN_CYCLES = 16;
    localparam int    STALL_LIMIT  = 1000;
    localparam int    MAX_REPORTS  = 10;
    // A table row with this text is checked against the predictor instead.
    localparam string WORKED_OUT   = "*";

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           in_valid  = 1'b0;
    nsm_pkg::byte_t in_byte   = '0;
    logic           out_ready = 1'b0;
    logic           in_ready;
    logic           out_valid;
    nsm_pkg::byte_t out_byte;
    logic           last_of_run;

    negation_scope_marker_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Directed text: a scope opened by a keyword and closed by a trailing comma,
    // a lone question mark ended by a newline, a lone full stop that turns out
    // to start a word, leading and collapsed spaces, and a non-ASCII keyword.
    nsm_pkg::byte_t dir_byte [DIRECTED] = '{
        "n", "o", " ", "a", ",", " ", 8'hFF, "\n",
        " ", "j", "a", "m", 8'hC3, 8'hA1, "s", " ", "?", "\n",
        "n", "i", " ", ".", "x", " ", " ", "\n"
    };
    string dir_want [DIRECTED] = '{
        "n", "o", "", " NEG_a", ",", "", WORKED_OUT, "\n",
        "", WORKED_OUT, WORKED_OUT, WORKED_OUT, WORKED_OUT, WORKED_OUT, WORKED_OUT,
        "", " ", "?\n",
        WORKED_OUT, WORKED_OUT, "", " ", "NEG_.x", "", "", " \n"
    };

    nsm_pkg::byte_t stim_byte [$];
    string          stim_want [$];
    int             counted_items;

    nsm_pkg::byte_t due_byte [$];
    logic           due_last [$];
    int             taken;
    int             mismatches;
    int             quiet_cycles;
    logic           tail = 1'b0;

    // Scope tracking state of the predictor.
    logic                          in_word;
    logic                          negating;
    logic                          holding;
    nsm_pkg::byte_t                held;
    nsm_pkg::byte_t                prev;
    logic [nsm_pkg::TOK_POS_W-1:0] tok_len;
    logic [nsm_pkg::KW_COUNT-1:0]  live_words;
    nsm_pkg::byte_t                run_out [$];

    function automatic string keyword_text(input int k);
        case (k)
            0:       return "nunca";
            1:       return "no";
            2:       return "nada";
            3:       return "ningun";
            4:       return "ni";
            5:       return "ninguno";
            6:       return "ninguna";
            7:       return "jam\303\241s";
            8:       return "jamas";
            9:       return "tampoco";
            default: return "sin";
        endcase
    endfunction

    function automatic logic is_stop(input nsm_pkg::byte_t b);
        return b == "?" || b == "," || b == ";" || b == "!" || b == "." || b == ":";
    endfunction

    function automatic nsm_pkg::byte_t any_stop();
        string s;
        s = "?,;!.:";
        return s[$urandom_range(0, 5)];
    endfunction

    function automatic logic word_is_keyword();
        string w;
        for (int k = 0; k < nsm_pkg::KW_COUNT; k++)
        begin
            w = keyword_text(k);
            if (live_words[k] && w.len() == tok_len)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic emit_tag();
        run_out.push_back("N");
        run_out.push_back("E");
        run_out.push_back("G");
        run_out.push_back("_");
    endtask

    task automatic take_word_byte(input nsm_pkg::byte_t b);
        string w;
        for (int k = 0; k < nsm_pkg::KW_COUNT; k++)
        begin
            w = keyword_text(k);
            if (live_words[k] && (tok_len >= w.len() || w[tok_len] != b))
                live_words[k] = 1'b0;
        end
        if (tok_len < nsm_pkg::KEYWORD_LENGTH_LIMIT)
            tok_len = tok_len + 1'b1;
        prev = b;
    endtask

    task automatic clear_word();
        tok_len    = '0;
        live_words = nsm_pkg::ALL_CANDIDATES;
    endtask

    // Works out the bytes that one input byte causes, into run_out.
    task automatic mark_byte(input nsm_pkg::byte_t b);
        run_out.delete();
        if (holding)
        begin
            holding = 1'b0;
            if (b == nsm_pkg::CHAR_SPACE || b == nsm_pkg::CHAR_NEWLINE)
            begin
                run_out.push_back(held);
                negating = 1'b0;
            end
            else
            begin
                emit_tag();
                run_out.push_back(held);
            end
        end
        if (b == nsm_pkg::CHAR_NEWLINE)
        begin
            if (prev == nsm_pkg::CHAR_SPACE)
                run_out.push_back(nsm_pkg::CHAR_SPACE);
            run_out.push_back(nsm_pkg::CHAR_NEWLINE);
            negating = 1'b0;
            in_word  = 1'b0;
            prev     = nsm_pkg::CHAR_NEWLINE;
            clear_word();
        end
        else if (b == nsm_pkg::CHAR_SPACE)
        begin
            if (in_word)
            begin
                if (negating)
                begin
                    if (is_stop(prev))
                        negating = 1'b0;
                end
                else if (word_is_keyword())
                begin
                    negating = 1'b1;
                end
                in_word = 1'b0;
                prev    = nsm_pkg::CHAR_SPACE;
                clear_word();
            end
        end
        else
        begin
            if (!in_word)
            begin
                if (prev == nsm_pkg::CHAR_SPACE)
                    run_out.push_back(nsm_pkg::CHAR_SPACE);
                in_word = 1'b1;
                clear_word();
                // Punctuation opening a word in scope waits for the next byte.
                if (negating && is_stop(b))
                begin
                    holding = 1'b1;
                    held    = b;
                end
                else if (negating)
                begin
                    emit_tag();
                end
            end
            if (!holding)
                run_out.push_back(b);
            take_word_byte(b);
        end
    endtask

    task automatic stim_push(input nsm_pkg::byte_t b);
        stim_byte.push_back(b);
        stim_want.push_back(WORKED_OUT);
        counted_items++;
    endtask

    task automatic stim_text(input string s, input int n);
        for (int i = 0; i < n; i++)
            stim_push(s[i]);
    endtask

    task automatic stim_word();
        int n;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
            stim_push(nsm_pkg::byte_t'($urandom_range("a", "z")));
    endtask

    // Mostly words and keywords with sensible spacing; the rest is near misses,
    // raw bytes and odd spacing.
    task automatic build_random_text();
        int    pick;
        int    sep;
        string w;
        while (counted_items < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            w    = keyword_text($urandom_range(0, nsm_pkg::KW_COUNT - 1));
            if (pick < 30)
            begin
                stim_text(w, w.len());
            end
            else if (pick < 45)
            begin
                stim_word();
            end
            else if (pick < 55)
            begin
                stim_push(any_stop());
            end
            else if (pick < 65)
            begin
                stim_word();
                stim_push(any_stop());
            end
            else if (pick < 70)
            begin
                stim_text(w, w.len() - 1);
            end
            else if (pick < 75)
            begin
                stim_text(w, w.len());
                stim_push(($urandom_range(0, 1) != 0) ? any_stop()
                          : nsm_pkg::byte_t'($urandom_range("a", "z")));
            end
            else if (pick < 85)
            begin
                for (int i = $urandom_range(1, 10); i > 0; i--)
                    stim_push(nsm_pkg::byte_t'($urandom_range(0, 255)));
            end
            sep = $urandom_range(0, 99);
            if (sep < 60)
            begin
                stim_push(nsm_pkg::CHAR_SPACE);
            end
            else if (sep < 75)
            begin
                stim_push(nsm_pkg::CHAR_SPACE);
                for (int i = $urandom_range(1, 2); i > 0; i--)
                    stim_push(nsm_pkg::CHAR_SPACE);
            end
            else if (sep < 87)
            begin
                stim_push(nsm_pkg::CHAR_NEWLINE);
            end
            else if (sep < 93)
            begin
                stim_push(nsm_pkg::CHAR_SPACE);
                stim_push(nsm_pkg::CHAR_NEWLINE);
            end
            else if (sep < 97)
            begin
                stim_push(nsm_pkg::CHAR_NEWLINE);
                for (int i = $urandom_range(1, 2); i > 0; i--)
                    stim_push(nsm_pkg::CHAR_SPACE);
            end
        end
    endtask

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    // Prediction on every input transfer, checking on every output transfer.
    always @(posedge clk)
    begin : scoreboard
        nsm_pkg::byte_t exp_b;
        logic           exp_l;
        string          want;
        if (in_valid && in_ready)
        begin
            mark_byte(in_byte);
            want = stim_want[taken];
            if (want == WORKED_OUT)
            begin
                foreach (run_out[i])
                begin
                    due_byte.push_back(run_out[i]);
                    due_last.push_back(i == run_out.size() - 1);
                end
            end
            else
            begin
                for (int i = 0; i < want.len(); i++)
                begin
                    due_byte.push_back(want[i]);
                    due_last.push_back(i == want.len() - 1);
                end
            end
            taken++;
        end
        if (out_valid && out_ready)
        begin
            if (due_byte.size() == 0)
            begin
                note_mismatch($sformatf("unexpected output: out_byte %02h last_of_run %0b",
                                        out_byte, last_of_run));
            end
            else
            begin
                exp_b = due_byte.pop_front();
                exp_l = due_last.pop_front();
                if (out_byte !== exp_b || last_of_run !== exp_l)
                    note_mismatch($sformatf(
                        "mismatch: out_byte %02h last_of_run %0b, expected %02h %0b",
                        out_byte, last_of_run, exp_b, exp_l));
            end
        end
    end

    // Ends a run in which no transfer happens for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Receiver: random stalls, with calm stretches and none near the end.
    initial
    begin : receiver
        int calm_left;
        calm_left = 0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (calm_left > 0)
                calm_left--;
            else if ($urandom_range(0, 19) == 0)
                calm_left = $urandom_range(10, 40);
            if (!tail && calm_left == 0 && $urandom_range(0, 2) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial
    begin : sender
        int calm_left;
        calm_left     = 0;
        taken         = 0;
        mismatches    = 0;
        quiet_cycles  = 0;
        counted_items = 0;
        in_word       = 1'b0;
        negating      = 1'b0;
        holding       = 1'b0;
        held          = '0;
        prev          = '0;
        clear_word();

        for (int i = 0; i < DIRECTED; i++)
        begin
            stim_byte.push_back(dir_byte[i]);
            stim_want.push_back(dir_want[i]);
        end
        build_random_text();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < stim_byte.size(); i++)
        begin
            if (i >= stim_byte.size() - TAIL_ITEMS)
                tail <= 1'b1;
            if (calm_left > 0)
                calm_left--;
            else if ($urandom_range(0, 19) == 0)
                calm_left = $urandom_range(10, 40);
            if (!tail && calm_left == 0 && $urandom_range(0, 3) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            in_valid <= 1'b1;
            in_byte  <= stim_byte[i];
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
        end
        in_valid <= 1'b0;

        // Let the last transfer reach the scoreboard before draining.
        @(posedge clk);
        wait (due_byte.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && due_byte.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

/* filelist.f */
src/nsm_pkg.sv
src/nsm_scan.sv
src/nsm_emit.sv
src/negation_scope_marker_core.sv
src/nsm_checker.sv
tb/negation_scope_marker_core_tb.sv
